// ===== sv/dsse_pkg.sv =====
package dsse_pkg;

	// Width of the binary input value.
	localparam int unsigned NUM_W = 63;
	// Width of one decimal digit.
	localparam int unsigned DIG_W = 4;
	// Width of one seven-segment pattern.
	localparam int unsigned SEG_W = 7;
	// Width of the counter over input bits.
	localparam int unsigned BIT_CNT_W = $clog2(NUM_W);

	// Seven-segment pattern of a decimal digit, bit 6 is segment a, bit 0 is segment g.
	function automatic logic [SEG_W-1:0] seg_code(input logic [DIG_W-1:0] d);
		logic [SEG_W-1:0] s;
		unique case (d)
			4'd0: s = 7'h7E;
			4'd1: s = 7'h30;
			4'd2: s = 7'h6D;
			4'd3: s = 7'h79;
			4'd4: s = 7'h33;
			4'd5: s = 7'h5B;
			4'd6: s = 7'h5F;
			4'd7: s = 7'h70;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h7B;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

// ===== sv/decimal_seven_segment_encoder_core.sv =====
// Converts a 63-bit unsigned number to decimal and streams its digits out, most significant
// first, one item per digit with its seven-segment pattern; tlast marks the least significant
// digit. Leading zeros are dropped, so zero gives the single digit 0. If the number has more
// than MAX_DIGITS digits, only its MAX_DIGITS least significant digits are sent, zeros
// included. An input item is taken in an idle cycle. Then follow the shift-and-add-3 conversion
// (one input bit per cycle through a BCD shift register), the dropping of leading zeros, and
// the sending of the digits, each one only while the sink is ready. A new number is taken only
// once the last digit of the previous one has been delivered.
module decimal_seven_segment_encoder_core
	import dsse_pkg::*;
#(
	parameter int unsigned MAX_DIGITS = 19
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [62:0] number, [63] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [3:0] digit, [10:4] segments, [15:11] zero
	output logic        m_tlast
);

	localparam int unsigned BCD_W = DIG_W * MAX_DIGITS;
	localparam int unsigned REM_W = $clog2(MAX_DIGITS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic [NUM_W-1:0]     num_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic [REM_W-1:0]     rem_q;
	logic                 ovf_q;
	logic [BCD_W-1:0]     bcd_adj;
	logic [DIG_W-1:0]     top_digit;

	// Add three to every digit of five or more before the next doubling.
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd_q[i*DIG_W +: DIG_W] >= 4'd5) begin
				bcd_adj[i*DIG_W +: DIG_W] = bcd_q[i*DIG_W +: DIG_W] + 4'd3;
			end else begin
				bcd_adj[i*DIG_W +: DIG_W] = bcd_q[i*DIG_W +: DIG_W];
			end
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: DIG_W];
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = (state_q == ST_EMIT);
	assign m_tdata   = {5'd0, seg_code(top_digit), top_digit};
	assign m_tlast   = (rem_q == REM_W'(1));

	// Sequencer: conversion, leading-zero skip and digit emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			num_q   <= '0;
			bcd_q   <= '0;
			cnt_q   <= '0;
			rem_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						num_q   <= s_tdata[NUM_W-1:0];
						bcd_q   <= '0;
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					// A carry out of the top digit means the number has too many digits.
					bcd_q <= {bcd_adj[BCD_W-2:0], num_q[NUM_W-1]};
					ovf_q <= ovf_q | bcd_adj[BCD_W-1];
					num_q <= {num_q[NUM_W-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == BIT_CNT_W'(NUM_W - 1)) begin
						rem_q   <= REM_W'(MAX_DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (!ovf_q && rem_q > REM_W'(1) && top_digit == '0) begin
						bcd_q <= bcd_q << DIG_W;
						rem_q <= rem_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						if (rem_q == REM_W'(1)) begin
							state_q <= ST_IDLE;
						end else begin
							bcd_q <= bcd_q << DIG_W;
						end
						rem_q <= rem_q - 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Conversion always takes cycles, so no digit appears right after an input item.
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid)
		else $error("digit offered straight after an input item");

	// Every digit offered is a decimal digit.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:0] <= 4'd9)
		else $error("digit offered is not decimal");

	// Delivering the last digit frees the input side.
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready)
		else $error("input not freed after last digit");

	// During conversion the bit counter stays below the input width.
	a_cnt_conv: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CONV |-> cnt_q < BIT_CNT_W'(NUM_W))
		else $error("bit counter out of step");

	// A digit count of zero is never seen while digits are offered.
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> rem_q != '0)
		else $error("digit offered with no digits left");

endmodule
